>>> design/dna_pkg.sv
package dna_pkg;

    // operand format
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;

    // quotient bits kept by the divider; anything at or above 2^QW saturates
    localparam int QW    = 33;
    localparam int MAG_W = QW + 1;

    // divider numerator/denominator widths for the value and derivative paths
    localparam int NRW = DATA_W + FRAC_BITS;
    localparam int DRW = DATA_W;
    localparam int NDW = 2 * DATA_W + FRAC_BITS;
    localparam int DDW = 2 * DATA_W;

    // compare widths, enough for the denominator at its largest shift
    localparam int CRW = ((NRW > DRW + QW) ? NRW : DRW + QW) + 1;
    localparam int CDW = ((NDW > DDW + QW) ? NDW : DDW + QW) + 1;

    // wide signed width used ahead of saturation
    localparam int WIDE_W = 2 * DATA_W + 2;

    // opcodes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } t_sat;

    // sideband carried alongside the divider
    typedef struct packed {
        logic [1:0]        op;
        logic              dbz;
        logic              rn;
        logic              dn;
        logic              ovf;
        logic [DATA_W-1:0] res_real;
        logic [DATA_W-1:0] res_dual;
    } t_side;

    // clamp a wide signed value to DATA_W bits
    function automatic t_sat sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] smax;
        logic signed [WIDE_W-1:0] smin;
        t_sat r;
        smax = (WIDE_W'(1) <<< (DATA_W - 1)) - WIDE_W'(1);
        smin = -(WIDE_W'(1) <<< (DATA_W - 1));
        r.ovf = 1'b0;
        if (v > smax) begin
            r.ovf = 1'b1;
            r.val = smax[DATA_W-1:0];
        end else if (v < smin) begin
            r.ovf = 1'b1;
            r.val = smin[DATA_W-1:0];
        end else begin
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // clamp a sign-magnitude value to DATA_W bits
    function automatic t_sat sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        t_sat r;
        lim = MAG_W'(1) << (DATA_W - 1);
        m = mag;
        r.ovf = 1'b0;
        if (neg) begin
            if (m > lim) begin
                r.ovf = 1'b1;
                m = lim;
            end
            r.val = DATA_W'(MAG_W'(0) - m);
        end else begin
            if (m > lim - MAG_W'(1)) begin
                r.ovf = 1'b1;
                m = lim - MAG_W'(1);
            end
            r.val = m[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/dna_divider.sv
module dna_divider (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dna_pkg::NRW-1:0]     i_num_r,
    input  logic [dna_pkg::DRW-1:0]     i_den_r,
    input  logic [dna_pkg::NDW-1:0]     i_num_d,
    input  logic [dna_pkg::DDW-1:0]     i_den_d,
    output logic [dna_pkg::MAG_W-1:0]   o_mag_r,
    output logic [dna_pkg::MAG_W-1:0]   o_mag_d
);
    import dna_pkg::*;

    logic [NRW-1:0] r_rem_r [0:QW];
    logic [DRW-1:0] r_den_r [0:QW];
    logic [QW-1:0]  r_q_r   [0:QW];
    logic           r_ov_r  [0:QW];
    logic [NDW-1:0] r_rem_d [0:QW];
    logic [DDW-1:0] r_den_d [0:QW];
    logic [QW-1:0]  r_q_d   [0:QW];
    logic           r_ov_d  [0:QW];

    logic [CRW-1:0] sh_r   [0:QW-1];
    logic [CDW-1:0] sh_d   [0:QW-1];
    logic           take_r [0:QW-1];
    logic           take_d [0:QW-1];

    // shifted divisor and trial compare, one restoring step per stage
    always_comb begin
        for (int s = 0; s < QW; s++) begin
            sh_r[s]   = CRW'(r_den_r[s]) << (QW - 1 - s);
            sh_d[s]   = CDW'(r_den_d[s]) << (QW - 1 - s);
            take_r[s] = CRW'(r_rem_r[s]) >= sh_r[s];
            take_d[s] = CDW'(r_rem_d[s]) >= sh_d[s];
        end
    end

    // stage 0 flags quotients of 2^QW or more, then one quotient bit a stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_r[0] <= i_num_r;
            r_den_r[0] <= i_den_r;
            r_q_r[0]   <= '0;
            r_ov_r[0]  <= CRW'(i_num_r) >= (CRW'(i_den_r) << QW);
            r_rem_d[0] <= i_num_d;
            r_den_d[0] <= i_den_d;
            r_q_d[0]   <= '0;
            r_ov_d[0]  <= CDW'(i_num_d) >= (CDW'(i_den_d) << QW);
            for (int s = 0; s < QW; s++) begin
                r_den_r[s+1] <= r_den_r[s];
                r_ov_r[s+1]  <= r_ov_r[s];
                r_den_d[s+1] <= r_den_d[s];
                r_ov_d[s+1]  <= r_ov_d[s];
                if (take_r[s]) begin
                    r_rem_r[s+1] <= NRW'(CRW'(r_rem_r[s]) - sh_r[s]);
                    r_q_r[s+1]   <= r_q_r[s] | (QW'(1) << (QW - 1 - s));
                end else begin
                    r_rem_r[s+1] <= r_rem_r[s];
                    r_q_r[s+1]   <= r_q_r[s];
                end
                if (take_d[s]) begin
                    r_rem_d[s+1] <= NDW'(CDW'(r_rem_d[s]) - sh_d[s]);
                    r_q_d[s+1]   <= r_q_d[s] | (QW'(1) << (QW - 1 - s));
                end else begin
                    r_rem_d[s+1] <= r_rem_d[s];
                    r_q_d[s+1]   <= r_q_d[s];
                end
            end
        end
    end

    // a too-large quotient reads as 2^QW, which always saturates
    assign o_mag_r = r_ov_r[QW] ? (MAG_W'(1) << QW) : {1'b0, r_q_r[QW]};
    assign o_mag_d = r_ov_d[QW] ? (MAG_W'(1) << QW) : {1'b0, r_q_d[QW]};

endmodule

>>> design/dual_number_alu.sv
// Dual-number ALU, signed Q16.16 operands: add, subtract, multiply and divide
// of (value, derivative) pairs. Fully pipelined: one request may enter every
// cycle, and each request passes stage 1 (products and sums), stage 2 (results
// and numerators), one divider range check, 33 restoring divider stages and
// the output register; every operation runs the same path so order is kept.
// The whole pipeline holds while a finished result is stalled at the output.
// Multiply results floor, divide results truncate towards zero, out-of-range
// parts saturate with overflow set; a zero divisor value gives zero results
// with div_by_zero set.
module dual_number_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [dna_pkg::DATA_W-1:0]   i_a_real,
    input  logic signed [dna_pkg::DATA_W-1:0]   i_a_dual,
    input  logic signed [dna_pkg::DATA_W-1:0]   i_b_real,
    input  logic signed [dna_pkg::DATA_W-1:0]   i_b_dual,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dna_pkg::DATA_W-1:0]   o_result_real,
    output logic signed [dna_pkg::DATA_W-1:0]   o_result_dual,
    output logic                                o_div_by_zero,
    output logic                                o_overflow
);
    import dna_pkg::*;

    logic w_en;

    // stage 1: products, sums, magnitudes
    logic                       r1_valid;
    logic [1:0]                 r1_op;
    logic signed [2*DATA_W-1:0] r1_rr, r1_rd, r1_dr, r1_bb;
    logic signed [DATA_W:0]     r1_sr, r1_sd;
    logic                       r1_an, r1_bn, r1_bz;
    logic [DATA_W-1:0]          r1_amag, r1_bmag;

    // stage 2: final results for add/sub/mul, numerators for divide
    logic                       r2_valid;
    t_side                      r2_side;
    logic [NRW-1:0]             r2_num_r;
    logic [DRW-1:0]             r2_den_r;
    logic [NDW-1:0]             r2_num_d;
    logic [DDW-1:0]             r2_den_d;

    logic signed [2*DATA_W:0]   w_sum;
    logic [2*DATA_W-1:0]        w_dmag;
    t_side                      n2_side;
    t_sat                       w_sr, w_sd;

    logic                       r_vld  [0:QW];
    t_side                      r_side [0:QW];
    logic [MAG_W-1:0]           w_mag_r, w_mag_d;

    t_sat                       w_qr, w_qd;

    // the pipeline moves unless a result waits at the output
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            for (int s = 0; s <= QW; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r_vld[0] <= r2_valid;
            for (int s = 0; s < QW; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
            o_valid <= r_vld[QW];
        end
    end

    // stage 1 data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op   <= i_op;
            r1_rr   <= i_a_real * i_b_real;
            r1_rd   <= i_a_real * i_b_dual;
            r1_dr   <= i_a_dual * i_b_real;
            r1_bb   <= i_b_real * i_b_real;
            if (i_op == OP_SUB) begin
                r1_sr <= (DATA_W+1)'(i_a_real) - (DATA_W+1)'(i_b_real);
                r1_sd <= (DATA_W+1)'(i_a_dual) - (DATA_W+1)'(i_b_dual);
            end else begin
                r1_sr <= (DATA_W+1)'(i_a_real) + (DATA_W+1)'(i_b_real);
                r1_sd <= (DATA_W+1)'(i_a_dual) + (DATA_W+1)'(i_b_dual);
            end
            r1_an   <= i_a_real[DATA_W-1];
            r1_bn   <= i_b_real[DATA_W-1];
            r1_bz   <= (i_b_real == '0);
            r1_amag <= i_a_real[DATA_W-1] ? (DATA_W'(0) - $unsigned(i_a_real))
                                          : $unsigned(i_a_real);
            r1_bmag <= i_b_real[DATA_W-1] ? (DATA_W'(0) - $unsigned(i_b_real))
                                          : $unsigned(i_b_real);
        end
    end

    // derivative sum: ad+bc for multiply, bc-ad for divide
    always_comb begin
        if (r1_op == OP_MUL) begin
            w_sum = (2*DATA_W+1)'(r1_rd) + (2*DATA_W+1)'(r1_dr);
        end else begin
            w_sum = (2*DATA_W+1)'(r1_dr) - (2*DATA_W+1)'(r1_rd);
        end
        w_dmag = w_sum[2*DATA_W] ? (2*DATA_W)'(-w_sum) : w_sum[2*DATA_W-1:0];
    end

    // results of the non-divide operations
    always_comb begin
        case (r1_op)
            OP_ADD, OP_SUB: begin
                w_sr = sat_wide(WIDE_W'(r1_sr));
                w_sd = sat_wide(WIDE_W'(r1_sd));
            end
            OP_MUL: begin
                w_sr = sat_wide(WIDE_W'(r1_rr) >>> FRAC_BITS);
                w_sd = sat_wide(WIDE_W'(w_sum) >>> FRAC_BITS);
            end
            default: begin
                w_sr = '0;
                w_sd = '0;
            end
        endcase
        n2_side.op       = r1_op;
        n2_side.dbz      = (r1_op == OP_DIV) && r1_bz;
        n2_side.rn       = r1_an ^ r1_bn;
        n2_side.dn       = w_sum[2*DATA_W];
        n2_side.ovf      = w_sr.ovf | w_sd.ovf;
        n2_side.res_real = w_sr.val;
        n2_side.res_dual = w_sd.val;
    end

    // stage 2 data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side  <= n2_side;
            r2_num_r <= NRW'(r1_amag) << FRAC_BITS;
            r2_den_r <= r1_bmag;
            r2_num_d <= NDW'(w_dmag) << FRAC_BITS;
            r2_den_d <= $unsigned(r1_bb);
        end
    end

    dna_divider u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num_r (r2_num_r),
        .i_den_r (r2_den_r),
        .i_num_d (r2_num_d),
        .i_den_d (r2_den_d),
        .o_mag_r (w_mag_r),
        .o_mag_d (w_mag_d)
    );

    // sideband delay matching the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r2_side;
            for (int s = 0; s < QW; s++) begin
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign w_qr = sat_mag(r_side[QW].rn, w_mag_r);
    assign w_qd = sat_mag(r_side[QW].dn, w_mag_d);

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[QW].op == OP_DIV) begin
                if (r_side[QW].dbz) begin
                    o_result_real <= '0;
                    o_result_dual <= '0;
                    o_div_by_zero <= 1'b1;
                    o_overflow    <= 1'b0;
                end else begin
                    o_result_real <= w_qr.val;
                    o_result_dual <= w_qd.val;
                    o_div_by_zero <= 1'b0;
                    o_overflow    <= w_qr.ovf | w_qd.ovf;
                end
            end else begin
                o_result_real <= r_side[QW].res_real;
                o_result_dual <= r_side[QW].res_dual;
                o_div_by_zero <= 1'b0;
                o_overflow    <= r_side[QW].ovf;
            end
        end
    end

endmodule

>>> design/dna_checker.sv
module dna_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [dna_pkg::DATA_W-1:0]   o_result_real,
    input  logic signed [dna_pkg::DATA_W-1:0]   o_result_dual,
    input  logic                                o_div_by_zero,
    input  logic                                o_overflow
);
    import dna_pkg::*;

    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_real)
                               && $stable(o_result_dual) && $stable(o_overflow))
        else $error("stalled result changed");

    // zero divisor gives zero parts and no overflow
    a_dbz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_result_real == '0 && o_result_dual == '0
                                     && !o_overflow)
        else $error("divide by zero result not cleared");

    // overflow means some part sits at a bound
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> $unsigned(o_result_real) == SMAX
            || $unsigned(o_result_real) == SMIN || $unsigned(o_result_dual) == SMAX
            || $unsigned(o_result_dual) == SMIN)
        else $error("overflow without saturated part");

    // stall only when a result waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output");

    // nothing comes out just after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result after reset");

endmodule

bind dual_number_alu dna_checker u_dna_checker (.*);
